@@ rtl/core/bdqd_pkg.sv @@
package bdqd_pkg;

    localparam int TDATA_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int PHASE_W   = 2;

    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

    localparam logic [PHASE_W-1:0] PHASE_ZERO  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONE   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_TWO   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_THREE = 2'd3;

    typedef struct packed {
        logic                clear_flags;
        logic [PHASE_W-1:0]  encoder_phase;
        logic                button_level;
    } sample_t;

    typedef struct packed {
        logic turn_event;
        logic turn_direction;
        logic button_event;
        logic button_pressed;
    } result_t;

    localparam int SAMPLE_W = $bits(sample_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/core/button_debounce_quadrature_decoder_unit.sv @@
// Button debouncer and quadrature encoder decoder.
// Input stream s_axis: one pin sample per transaction. The debounced button
// state changes only after a run of equal samples longer than the threshold;
// each change sets a sticky button event. Leaving encoder phase 0 or 3 for
// phase 1 or 2 gives a turn direction and sets a sticky turn event. A clear bit
// in the sample drops both sticky events before the sample is applied.
// Output stream m_axis: one result transaction per input transaction, in order.
// Configuration: cfg_wr_en writes cfg_wr_data to the debounce threshold; write
// only while no transaction is in flight.
// Path: input register, then result register; the update logic sits between
// them and is combinational. Throughput: one transaction per cycle while
// m_axis_tready does not stall the output.
// Reset: threshold 10, button released, counters and phase 0, events clear,
// no result pending.
// Stall: while m_axis_tready is low the result holds; the input register still
// takes one more transaction, after which s_axis_tready drops.
module button_debounce_quadrature_decoder_unit
    import bdqd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [0] button_level, [2:1] encoder_phase, [3] clear_flags, [7:4] zero
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] button_pressed, [1] button_event, [2] turn_direction, [3] turn_event,
    // [7:4] zero
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic [COUNT_W-1:0] threshold_reg;
    logic               in_valid_reg;
    sample_t            in_data_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               released_reg, released_next;
    logic [COUNT_W-1:0] press_cnt_reg, press_cnt_next;
    logic [COUNT_W-1:0] release_cnt_reg, release_cnt_next;
    logic [PHASE_W-1:0] phase_reg;
    logic               dir_reg, dir_next;
    logic               button_flag_reg, button_flag_next;
    logic               turn_flag_reg, turn_flag_next;
    result_t            out_data_next;

    logic advance;
    logic [COUNT_W-1:0] press_inc;
    logic [COUNT_W-1:0] release_inc;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - RESULT_W)'(0), out_data_reg};

    assign press_inc   = (press_cnt_reg == COUNT_MAX) ? press_cnt_reg
                                                      : press_cnt_reg + 1'b1;
    assign release_inc = (release_cnt_reg == COUNT_MAX) ? release_cnt_reg
                                                        : release_cnt_reg + 1'b1;

    always_comb
    begin
        released_next    = released_reg;
        press_cnt_next   = press_cnt_reg;
        release_cnt_next = release_cnt_reg;
        dir_next         = dir_reg;
        button_flag_next = button_flag_reg && !in_data_reg.clear_flags;
        turn_flag_next   = turn_flag_reg && !in_data_reg.clear_flags;

        if (!in_data_reg.button_level)
        begin
            press_cnt_next   = press_inc;
            release_cnt_next = '0;
            if ((press_inc > threshold_reg) && released_reg)
            begin
                released_next    = 1'b0;
                button_flag_next = 1'b1;
            end
        end
        else
        begin
            release_cnt_next = release_inc;
            press_cnt_next   = '0;
            if ((release_inc > threshold_reg) && !released_reg)
            begin
                released_next    = 1'b1;
                button_flag_next = 1'b1;
            end
        end

        if (phase_reg == PHASE_ZERO)
        begin
            case (in_data_reg.encoder_phase)
                PHASE_TWO:
                begin
                    dir_next       = 1'b0;
                    turn_flag_next = 1'b1;
                end
                PHASE_ONE:
                begin
                    dir_next       = 1'b1;
                    turn_flag_next = 1'b1;
                end
                default: ;
            endcase
        end
        else if (phase_reg == PHASE_THREE)
        begin
            case (in_data_reg.encoder_phase)
                PHASE_ONE:
                begin
                    dir_next       = 1'b0;
                    turn_flag_next = 1'b1;
                end
                PHASE_TWO:
                begin
                    dir_next       = 1'b1;
                    turn_flag_next = 1'b1;
                end
                default: ;
            endcase
        end

        out_data_next.button_pressed = !released_next;
        out_data_next.button_event   = button_flag_next;
        out_data_next.turn_direction = dir_next;
        out_data_next.turn_event     = turn_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            released_reg    <= 1'b1;
            press_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            phase_reg       <= PHASE_ZERO;
            dir_reg         <= 1'b0;
            button_flag_reg <= 1'b0;
            turn_flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    released_reg    <= released_next;
                    press_cnt_reg   <= press_cnt_next;
                    release_cnt_reg <= release_cnt_next;
                    phase_reg       <= in_data_reg.encoder_phase;
                    dir_reg         <= dir_next;
                    button_flag_reg <= button_flag_next;
                    turn_flag_reg   <= turn_flag_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/core/bdqd_checker.sv @@
module bdqd_checker
    import bdqd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transaction changed");

    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:RESULT_W] == '0)
        else $error("result padding bits not zero");

    // an empty output stage must never block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output register empty");

    // a sample accepted with no pending result shows up after the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result transaction missing after accepted sample");

endmodule

bind button_debounce_quadrature_decoder_unit bdqd_checker u_bdqd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/button_debounce_quadrature_decoder_unit_test.sv @@
`timescale 1ns / 100ps

module button_debounce_quadrature_decoder_unit_test;
    import bdqd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIRECTED_ROWS = 23;
    localparam int PHASE_COUNT   = 7;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_RUN      = 300;

    // Gray order of the encoder phases, position 0 in the lowest bits
    localparam logic [4*PHASE_W-1:0] GRAY_ORDER =
        {PHASE_TWO, PHASE_THREE, PHASE_ONE, PHASE_ZERO};

    typedef struct packed {
        logic    exact;
        result_t res;
        sample_t smp;
    } directed_row_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b1;
    logic               cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    // predictor state
    logic [COUNT_W-1:0] thr_setting;
    logic               deb_released;
    logic [COUNT_W-1:0] press_run;
    logic [COUNT_W-1:0] release_run;
    logic [PHASE_W-1:0] prev_phase;
    logic               pressed_q;
    logic               dir_q;
    logic               btn_evt_q;
    logic               turn_evt_q;

    result_t       pending_results[$];
    directed_row_t directed_rows[DIRECTED_ROWS];

    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      burst_left     = 0;
    bit      gaps_on        = 1'b1;
    int      stall_mode     = 0;
    int      hold_grant     = 0;
    int      hold_seen      = 0;
    int      hold_left      = 0;
    int      stall_tick     = 0;
    result_t got_res;
    result_t want_res;

    button_debounce_quadrature_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic result_t debounce_and_decode(input sample_t smp);
        result_t r;
        if (smp.clear_flags)
        begin
            btn_evt_q  = 1'b0;
            turn_evt_q = 1'b0;
        end
        if (!smp.button_level)
        begin
            if (press_run != COUNT_MAX)
                press_run = press_run + 1'b1;
            release_run = '0;
            if (press_run > thr_setting && deb_released)
            begin
                deb_released = 1'b0;
                pressed_q    = 1'b1;
                btn_evt_q    = 1'b1;
            end
        end
        else
        begin
            if (release_run != COUNT_MAX)
                release_run = release_run + 1'b1;
            press_run = '0;
            if (release_run > thr_setting && !deb_released)
            begin
                deb_released = 1'b1;
                pressed_q    = 1'b0;
                btn_evt_q    = 1'b1;
            end
        end
        if (smp.encoder_phase != prev_phase)
        begin
            if (prev_phase == PHASE_ZERO && smp.encoder_phase == PHASE_TWO)
            begin
                dir_q      = 1'b0;
                turn_evt_q = 1'b1;
            end
            else if (prev_phase == PHASE_ZERO && smp.encoder_phase == PHASE_ONE)
            begin
                dir_q      = 1'b1;
                turn_evt_q = 1'b1;
            end
            else if (prev_phase == PHASE_THREE && smp.encoder_phase == PHASE_ONE)
            begin
                dir_q      = 1'b0;
                turn_evt_q = 1'b1;
            end
            else if (prev_phase == PHASE_THREE && smp.encoder_phase == PHASE_TWO)
            begin
                dir_q      = 1'b1;
                turn_evt_q = 1'b1;
            end
            prev_phase = smp.encoder_phase;
        end
        r.button_pressed = pressed_q;
        r.button_event   = btn_evt_q;
        r.turn_direction = dir_q;
        r.turn_event     = turn_evt_q;
        return r;
    endfunction

    function automatic directed_row_t make_row(input logic level, input logic [PHASE_W-1:0] ph,
                                               input logic clr, input logic exact,
                                               input result_t res);
        directed_row_t row;
        row.smp.button_level  = level;
        row.smp.encoder_phase = ph;
        row.smp.clear_flags   = clr;
        row.exact             = exact;
        row.res               = res;
        return row;
    endfunction

    task automatic log_mismatch(input string what, input result_t want,
                                input logic [TDATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch at %0t: %s, expected %b got %b ",
                      "(bit 0 up: pressed, button event, direction, turn event)"},
                     $realtime, what, want, got);
    endtask

    task automatic send_sample(input sample_t smp, input logic exact, input result_t typed);
        int      gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= TDATA_W'(smp);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = debounce_and_decode(smp);
        pending_results.push_back(exact ? typed : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thr_setting = value;
    endtask

    // receiver: check each result transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
                log_mismatch("result with nothing pending", '0, m_axis_tdata);
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.button_pressed !== want_res.button_pressed
                    || got_res.button_event !== want_res.button_event
                    || got_res.turn_direction !== want_res.turn_direction
                    || got_res.turn_event !== want_res.turn_event
                    || m_axis_tdata[TDATA_W-1:RESULT_W] !== '0)
                    log_mismatch("wrong result", want_res, m_axis_tdata);
            end
        end
        stall_tick++;
        if (hold_seen != hold_grant)
        begin
            hold_seen = hold_grant;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= (stall_tick % 7 != 2) && (stall_tick % 7 != 3);
                default: m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL button_debounce_quadrature_decoder_unit");
            $finish;
        end
    end

    initial
    begin
        int          p;
        int          k;
        int          budget;
        int          phase_items;
        int          run_len;
        int          run_max;
        int          enc_pos;
        int          enc_step;
        int          pick;
        logic [7:0]  thr;
        logic        level;
        bit          first_run;
        sample_t     smp;

        rst_n <= 1'b0;

        thr_setting  = THRESHOLD_RESET;
        deb_released = 1'b1;
        press_run    = '0;
        release_run  = '0;
        prev_phase   = PHASE_ZERO;
        pressed_q    = 1'b0;
        dir_q        = 1'b0;
        btn_evt_q    = 1'b0;
        turn_evt_q   = 1'b0;

        // walk the phases both ways, jump 0<->3, clear, then press past the reset threshold
        directed_rows[0]  = make_row(1'b1, PHASE_ZERO,  1'b0, 1'b1, 4'b0000);
        directed_rows[1]  = make_row(1'b1, PHASE_TWO,   1'b0, 1'b1, 4'b1000);
        directed_rows[2]  = make_row(1'b1, PHASE_THREE, 1'b0, 1'b0, '0);
        directed_rows[3]  = make_row(1'b1, PHASE_ONE,   1'b0, 1'b0, '0);
        directed_rows[4]  = make_row(1'b1, PHASE_THREE, 1'b0, 1'b0, '0);
        directed_rows[5]  = make_row(1'b1, PHASE_TWO,   1'b0, 1'b0, '0);
        directed_rows[6]  = make_row(1'b1, PHASE_ZERO,  1'b0, 1'b0, '0);
        directed_rows[7]  = make_row(1'b1, PHASE_ONE,   1'b0, 1'b0, '0);
        directed_rows[8]  = make_row(1'b1, PHASE_ZERO,  1'b0, 1'b0, '0);
        directed_rows[9]  = make_row(1'b1, PHASE_THREE, 1'b0, 1'b0, '0);
        directed_rows[10] = make_row(1'b1, PHASE_ZERO,  1'b0, 1'b0, '0);
        directed_rows[11] = make_row(1'b1, PHASE_ZERO,  1'b1, 1'b1, 4'b0100);
        for (k = 12; k < DIRECTED_ROWS - 1; k++)
            directed_rows[k] = make_row(1'b0, PHASE_ZERO, 1'b0, 1'b0, '0);
        directed_rows[DIRECTED_ROWS-1] = make_row(1'b0, PHASE_TWO, 1'b1, 1'b1, 4'b1011);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_mode = 1;
        for (k = 0; k < DIRECTED_ROWS; k++)
            send_sample(directed_rows[k].smp, directed_rows[k].exact, directed_rows[k].res);
        drain_results();

        level   = 1'b1;
        enc_pos = 0;
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin thr = 8'd0;   budget = 150; end
                1: begin thr = 8'd1;   budget = 150; end
                2: begin thr = 8'd2;   budget = 150; end
                3: begin thr = 8'd5;   budget = 200; end
                4: begin thr = 8'd10;  budget = 250; end
                5: begin thr = 8'd255; budget = 650; end
                default: begin thr = 8'd3; budget = 100; end
            endcase
            write_threshold(thr);
            stall_mode = p % 4;
            gaps_on    = (p != 2);
            if (p == 4)
                hold_grant++;
            first_run   = (thr == COUNT_MAX);
            phase_items = 0;
            while (phase_items < budget)
            begin
                run_max = (thr > 8'd200) ? LONG_RUN : thr + 4;
                if (first_run)
                begin
                    level     = 1'b0;
                    run_len   = LONG_RUN;
                    first_run = 1'b0;
                end
                else
                begin
                    level = ~level;
                    pick  = $urandom_range(0, 9);
                    if (pick < 3)
                        run_len = $urandom_range(1, 3);
                    else if (pick == 9)
                        run_len = $urandom_range(250, LONG_RUN);
                    else
                        run_len = $urandom_range(1, run_max);
                end
                enc_step = $urandom_range(0, 1) ? 1 : 3;
                for (k = 0; k < run_len && phase_items < budget; k++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 9)
                        enc_pos = $urandom_range(0, 3);
                    else if (pick >= 4)
                        enc_pos = (enc_pos + enc_step) % 4;
                    smp.button_level  = level;
                    smp.encoder_phase = GRAY_ORDER[enc_pos*PHASE_W +: PHASE_W];
                    smp.clear_flags   = ($urandom_range(0, 15) == 0);
                    send_sample(smp, 1'b0, '0);
                    phase_items++;
                    if (p == 3 && phase_items == budget / 2)
                        drain_results();
                end
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS button_debounce_quadrature_decoder_unit");
        else
            $display("FAIL button_debounce_quadrature_decoder_unit");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bdqd_pkg.sv
rtl/core/button_debounce_quadrature_decoder_unit.sv
rtl/core/bdqd_checker.sv
tb/sv/button_debounce_quadrature_decoder_unit_test.sv
